FILE: design/ksda_pkg.sv
`timescale 1ns / 1ps

package ksda_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = FRAC_BITS + 1;
	localparam int COUNT_W   = 16;
	localparam int STEP_W    = $clog2(FRAC_BITS);
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [VAL_W-1:0]   ONE_VAL   = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [MODE_W-1:0] MODE_POINT        = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GROUPED      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GROUPED_PREV = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'd1;

	typedef struct packed {
		logic [VAL_W-1:0]   cdf_value;
		logic [COUNT_W-1:0] item_count;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [VAL_W-1:0] dist_plus;
		logic [VAL_W-1:0] dist_minus;
		logic [VAL_W-1:0] dist_max;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic update;
	} ksda_cmd_t;

	typedef struct packed {
		logic last;
		logic out_busy;
	} ksda_sts_t;

endpackage

FILE: design/ksda_ctrl.sv
`timescale 1ns / 1ps

module ksda_ctrl
	import ksda_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  ksda_sts_t sts,
	output ksda_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FRAC_BITS - 1);

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              accept;
	logic              upd_go;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign upd_go   = (state_q == ST_UPD) && !(sts.last && sts.out_busy);

	always_comb begin
		cmd.load     = accept;
		cmd.div_step = (state_q == ST_DIV);
		cmd.update   = upd_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_LAST) begin
						state_q <= ST_UPD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_UPD: begin
					if (upd_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// An accepted item always starts a fresh division.
	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DIV) && (step_q == '0))
		else $error("accepted item did not start the divider");

	a_div_ends_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (step_q == STEP_LAST) |=> (state_q == ST_UPD))
		else $error("divider did not hand over to the update step");

	a_update_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		upd_go |=> (state_q == ST_IDLE))
		else $error("update step did not return to idle");

	a_no_update_on_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.last && sts.out_busy) |-> !cmd.update)
		else $error("final item updated while the output register was held");

endmodule

FILE: design/ksda_datapath.sv
`timescale 1ns / 1ps

module ksda_datapath
	import ksda_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  ksda_cmd_t          cmd,
	output ksda_sts_t          sts,
	input  in_item_t           in_data,
	input  logic [MODE_W-1:0]  mode,
	input  logic [COUNT_W-1:0] total_count,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data
);

	logic [COUNT_W-1:0]   running_q;
	logic [VAL_W-1:0]     prev_q;
	logic [VAL_W-1:0]     max_plus_q;
	logic [VAL_W-1:0]     max_minus_q;
	logic                 out_valid_q;
	out_item_t            out_data_q;

	logic [VAL_W-1:0]     f_q;
	logic [COUNT_W-1:0]   n_q;
	logic [COUNT_W-1:0]   rem_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic                 sat_q;
	logic                 last_q;
	logic                 use_prev_q;

	logic [VAL_W-1:0]     cdf_sat;
	logic [COUNT_W-1:0]   cnt_eff;
	logic [COUNT_W:0]     cnt_sum;
	logic [COUNT_W-1:0]   rc_new;
	logic [COUNT_W-1:0]   n_eff;
	logic [COUNT_W:0]     two_r;
	logic [COUNT_W:0]     two_r_sub;
	logic                 r_ge;
	logic [VAL_W-1:0]     e_val;
	logic [VAL_W-1:0]     ref_minus;
	logic [VAL_W-1:0]     diff_plus;
	logic [VAL_W-1:0]     diff_minus;
	logic [VAL_W-1:0]     plus_new;
	logic [VAL_W-1:0]     minus_new;
	logic [VAL_W-1:0]     max_new;

	always_comb begin
		cdf_sat = (in_data.cdf_value > ONE_VAL) ? ONE_VAL : in_data.cdf_value;
		cnt_eff = (mode == MODE_POINT) ? COUNT_W'(1) : in_data.item_count;
		cnt_sum = {1'b0, running_q} + {1'b0, cnt_eff};
		rc_new  = cnt_sum[COUNT_W] ? COUNT_MAX : cnt_sum[COUNT_W-1:0];
		n_eff   = (total_count == '0) ? COUNT_W'(1) : total_count;

		two_r     = {rem_q, 1'b0};
		two_r_sub = two_r - {1'b0, n_q};
		r_ge      = (two_r >= {1'b0, n_q});

		e_val      = sat_q ? ONE_VAL : {1'b0, quo_q};
		ref_minus  = use_prev_q ? prev_q : e_val;
		diff_plus  = e_val - f_q;
		diff_minus = f_q - ref_minus;
		plus_new   = ((e_val > f_q) && (diff_plus > max_plus_q)) ? diff_plus : max_plus_q;
		minus_new  = ((f_q > ref_minus) && (diff_minus > max_minus_q)) ?
			diff_minus : max_minus_q;
		max_new    = (plus_new > minus_new) ? plus_new : minus_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= '0;
			prev_q      <= '0;
			max_plus_q  <= '0;
			max_minus_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				running_q <= rc_new;
			end
			if (cmd.update) begin
				if (last_q) begin
					running_q   <= '0;
					prev_q      <= '0;
					max_plus_q  <= '0;
					max_minus_q <= '0;
				end else begin
					prev_q      <= e_val;
					max_plus_q  <= plus_new;
					max_minus_q <= minus_new;
				end
			end
			if (cmd.update && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			f_q        <= cdf_sat;
			n_q        <= n_eff;
			rem_q      <= rc_new;
			sat_q      <= (rc_new >= n_eff);
			last_q     <= in_data.last;
			use_prev_q <= (mode == MODE_POINT) || (mode == MODE_GROUPED_PREV);
		end else if (cmd.div_step) begin
			rem_q <= r_ge ? two_r_sub[COUNT_W-1:0] : two_r[COUNT_W-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], r_ge};
		end
		if (cmd.update && last_q) begin
			out_data_q.dist_plus  <= plus_new;
			out_data_q.dist_minus <= minus_new;
			out_data_q.dist_max   <= max_new;
		end
	end

	assign sts.last     = last_q;
	assign sts.out_busy = out_valid_q && out_stall;
	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;

endmodule

FILE: design/ks_distance_accumulator_unit.sv
`timescale 1ns / 1ps

// Kolmogorov-Smirnov distance accumulator.
// Each input item carries the model CDF value of the next sorted sample or bin,
// its sample count and a last flag; the block tracks D+ and D- over the run.
// Configuration is written through cfg_valid/cfg_ready with cfg_index 0 for the
// mode and 1 for the total sample count; cfg_ready is always high, and writes
// are expected only while no item is in flight.
// An item is accepted when in_valid is high and in_stall is low. Each item
// then passes through the bit-serial restoring divider that forms the empirical
// fraction and then through an update step; in_stall stays high from acceptance
// until that update step completes.
// Only an item with last set produces a result. out_valid rises at the edge
// that ends the update step. The run state then clears for the next run.
// The result waits in the output register while out_stall is high; a further
// item is still accepted and processed, and only a following last item holds
// in its update step until the waiting result has been taken.
// Reset sets mode 0, total count 1 and clears all run state and out_valid.

module ks_distance_accumulator_unit
	import ksda_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [MODE_W-1:0]  mode_q;
	logic [COUNT_W-1:0] total_q;
	ksda_cmd_t          cmd;
	ksda_sts_t          sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_POINT;
			total_q <= COUNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE:  mode_q  <= cfg_data[MODE_W-1:0];
				CFG_TOTAL: total_q <= cfg_data[COUNT_W-1:0];
				default:   mode_q  <= mode_q;
			endcase
		end
	end

	ksda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ksda_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_data     (in_data),
		.mode        (mode_q),
		.total_count (total_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule
